### rtl/core/uart_line_config_encoder_unit_macros.svh
// Assertion macros used by the RTL of the line configuration encoder.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef UART_LINE_CONFIG_ENCODER_UNIT_MACROS_SVH
`define UART_LINE_CONFIG_ENCODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ULCE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ulce assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ULCE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ulce assertion failed");

`endif

### rtl/core/ulce_pkg.sv
package ulce_pkg;

	localparam int unsigned BAUD_W   = 24;
	localparam int unsigned FMT_W    = 8;
	localparam int unsigned DIV_W    = 16;
	localparam int unsigned LC_W     = 5;
	localparam int unsigned DIV_BITS = 21;

	// Each cell retires this many quotient bits per cycle when it is not stalled.
	localparam int unsigned CELL_STEPS  = 3;
	localparam int unsigned CHAIN_CELLS = DIV_BITS / CELL_STEPS;

	localparam logic [DIV_BITS-1:0] CLOCK_RATE = 21'd1500000;
	localparam logic [BAUD_W-1:0]   BAUD_MIN   = 24'd23;
	localparam logic [BAUD_W-1:0]   BAUD_MAX   = 24'd1500000;

	// Word length codes.
	localparam logic [2:0] WORD_8 = 3'd0;
	localparam logic [2:0] WORD_7 = 3'd1;
	localparam logic [2:0] WORD_6 = 3'd2;
	localparam logic [2:0] WORD_5 = 3'd3;

	// Parity codes.
	localparam logic [2:0] PAR_NONE = 3'd0;
	localparam logic [2:0] PAR_ODD  = 3'd1;
	localparam logic [2:0] PAR_EVEN = 3'd2;

	// Stop bit codes.
	localparam logic [1:0] STOP_1   = 2'd0;
	localparam logic [1:0] STOP_1P5 = 2'd1;
	localparam logic [1:0] STOP_2   = 2'd2;

	typedef struct packed {
		logic             ok;
		logic [LC_W-1:0]  lc;
		logic [DIV_W-1:0] div;
	} ulce_side_t;

	typedef struct packed {
		logic [DIV_BITS-1:0] rem;
		logic [DIV_BITS-1:0] quo;
		logic [DIV_BITS-1:0] den;
		ulce_side_t          side;
	} ulce_cell_t;

	function automatic logic [1:0] len_code(input logic [2:0] word);
		logic [1:0] code;
		unique case (word)
			WORD_8:  code = 2'd3;
			WORD_7:  code = 2'd2;
			WORD_6:  code = 2'd1;
			WORD_5:  code = 2'd0;
			default: code = 2'd0;
		endcase
		return code;
	endfunction

	function automatic logic [1:0] par_code(input logic [2:0] par);
		logic [1:0] code;
		unique case (par)
			PAR_NONE: code = 2'd0;
			PAR_ODD:  code = 2'd1;
			PAR_EVEN: code = 2'd3;
			default:  code = 2'd0;
		endcase
		return code;
	endfunction

	function automatic logic stop_code(input logic [1:0] stop);
		logic code;
		unique case (stop)
			STOP_1:   code = 1'b0;
			STOP_1P5: code = 1'b1;
			STOP_2:   code = 1'b1;
			default:  code = 1'b0;
		endcase
		return code;
	endfunction

endpackage

### rtl/core/ulce_req_if.sv
interface ulce_req_if;
	import ulce_pkg::*;

	logic              valid;
	logic              ready;
	logic [BAUD_W-1:0] baud_rate;
	logic [FMT_W-1:0]  line_format;

	modport source (output valid, output baud_rate, output line_format, input ready);
	modport sink (input valid, input baud_rate, input line_format, output ready);
endinterface

### rtl/core/ulce_rsp_if.sv
interface ulce_rsp_if;
	import ulce_pkg::*;

	logic                valid;
	logic                ready;
	logic                accepted;
	logic [DIV_W-1:0]    divisor;
	logic [LC_W-1:0]     line_control;
	logic [DIV_BITS-1:0] actual_baud;

	modport source (
		output valid, output accepted, output divisor, output line_control,
		output actual_baud, input ready
	);
	modport sink (
		input valid, input accepted, input divisor, input line_control,
		input actual_baud, output ready
	);
endinterface

### rtl/core/uart_line_config_encoder_unit.sv
// UART line configuration encoder.
// A request word on req carries a baud rate and a packed line format. The block checks
// that the baud rate lies in 23..1500000 and that the word, parity and stop codes are legal
// (1.5 stop bits only with 5-bit words). Every request produces exactly one response word
// on rsp: accepted, the 16-bit divisor 1500000/baud, the 5-bit line control value and the
// baud rate that the divisor really gives, 1500000/divisor. A rejected request answers
// with all fields zero.
// Both channels use valid/ready; a word moves at a clock edge where both are high.
// A request passes through two chains of 7 cells, each cell retiring 3 quotient bits of a
// restoring division per cycle while it is not stalled. The first chain forms the divisor,
// the second divides the clock rate by that divisor. Throughput is one word per cycle
// while rsp is ready; every cell is a pipeline stage with its own valid bit.
// When rsp stalls, words keep moving forward into empty cells, so req stays ready until
// every cell holds a word; only then does the stall reach req.
// The asynchronous reset empties all cells; no word is in flight after reset.
module uart_line_config_encoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	ulce_req_if.sink   req,
	ulce_rsp_if.source rsp
);
	import ulce_pkg::*;

	`include "uart_line_config_encoder_unit_macros.svh"

	logic [2:0] word;
	logic [2:0] par;
	logic [1:0] stop;
	logic       fmt_ok;
	logic       baud_ok;

	ulce_cell_t c1_in;
	ulce_cell_t c1_out;
	ulce_cell_t c2_in;
	ulce_cell_t c2_out;
	logic       c1_valid;
	logic       c1_ready;

	// Format decode and range check happen as the request enters the first cell.
	assign word = req.line_format[2:0];
	assign par  = req.line_format[5:3];
	assign stop = req.line_format[7:6];

	assign baud_ok = (req.baud_rate >= BAUD_MIN) && (req.baud_rate <= BAUD_MAX);
	assign fmt_ok  = (word <= WORD_5) && (par <= PAR_EVEN) && (stop <= STOP_2) &&
		((stop != STOP_1P5) || (word == WORD_5));

	always_comb begin
		c1_in         = '0;
		c1_in.den     = req.baud_rate[DIV_BITS-1:0];
		c1_in.side.ok = baud_ok && fmt_ok;
		c1_in.side.lc = {par_code(par), stop_code(stop), len_code(word)};
	end

	// First chain: divisor = clock rate / baud.
	ulce_div_chain u_chain_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (req.valid),
		.up_ready (req.ready),
		.up_data  (c1_in),
		.dn_valid (c1_valid),
		.dn_ready (c1_ready),
		.dn_data  (c1_out)
	);

	// The divisor becomes the denominator of the second chain and rides along as side data.
	always_comb begin
		c2_in          = '0;
		c2_in.den      = {{(DIV_BITS - DIV_W){1'b0}}, c1_out.quo[DIV_W-1:0]};
		c2_in.side.ok  = c1_out.side.ok;
		c2_in.side.lc  = c1_out.side.lc;
		c2_in.side.div = c1_out.quo[DIV_W-1:0];
	end

	// Second chain: actual baud = clock rate / divisor.
	ulce_div_chain u_chain_act (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (c1_valid),
		.up_ready (c1_ready),
		.up_data  (c2_in),
		.dn_valid (rsp.valid),
		.dn_ready (rsp.ready),
		.dn_data  (c2_out)
	);

	// A rejected request reports zeros regardless of what the dividers produced.
	assign rsp.accepted     = c2_out.side.ok;
	assign rsp.divisor      = c2_out.side.ok ? c2_out.side.div : '0;
	assign rsp.line_control = c2_out.side.ok ? c2_out.side.lc : '0;
	assign rsp.actual_baud  = c2_out.side.ok ? c2_out.quo : '0;

	`ULCE_ASSERT_SAME(a_accept_nonzero, rsp.valid && rsp.accepted,
		(rsp.divisor != '0) && (rsp.actual_baud >= DIV_BITS'(BAUD_MIN)))
	`ULCE_ASSERT_SAME(a_reject_zero, rsp.valid && !rsp.accepted,
		(rsp.divisor == '0) && (rsp.line_control == '0) && (rsp.actual_baud == '0))
	`ULCE_ASSERT_SAME(a_empty_out_ready, !rsp.valid, req.ready)
endmodule

### rtl/core/ulce_div_cell.sv
module ulce_div_cell #(
	parameter int unsigned START = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  ulce_pkg::ulce_cell_t up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output ulce_pkg::ulce_cell_t dn_data
);
	import ulce_pkg::*;

	// Dividend bits this cell brings down, most significant first.
	localparam logic [CELL_STEPS-1:0] DBITS = CLOCK_RATE[START -: CELL_STEPS];

	logic                valid_q;
	ulce_cell_t          data_q;
	ulce_cell_t          nxt;
	logic [DIV_BITS:0]   trial;
	logic                qbit;

	// Restoring division: shift in a dividend bit, subtract the divisor when it fits.
	always_comb begin
		nxt   = up_data;
		trial = '0;
		qbit  = 1'b0;
		for (int k = 0; k < CELL_STEPS; k++) begin
			trial = {nxt.rem, DBITS[CELL_STEPS-1-k]};
			if (trial >= {1'b0, nxt.den}) begin
				trial = trial - {1'b0, nxt.den};
				qbit  = 1'b1;
			end else begin
				qbit  = 1'b0;
			end
			nxt.rem = trial[DIV_BITS-1:0];
			nxt.quo = {nxt.quo[DIV_BITS-2:0], qbit};
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;
endmodule

### rtl/core/ulce_div_chain.sv
module ulce_div_chain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  ulce_pkg::ulce_cell_t up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output ulce_pkg::ulce_cell_t dn_data
);
	import ulce_pkg::*;

	logic [CHAIN_CELLS:0] link_valid;
	logic [CHAIN_CELLS:0] link_ready;
	ulce_cell_t           link_data [CHAIN_CELLS+1];

	assign link_valid[0] = up_valid;
	assign link_data[0]  = up_data;
	assign up_ready      = link_ready[0];

	for (genvar i = 0; i < CHAIN_CELLS; i++) begin : g_cell
		ulce_div_cell #(
			.START(DIV_BITS - 1 - i * CELL_STEPS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_valid[i]),
			.up_ready (link_ready[i]),
			.up_data  (link_data[i]),
			.dn_valid (link_valid[i+1]),
			.dn_ready (link_ready[i+1]),
			.dn_data  (link_data[i+1])
		);
	end

	assign dn_valid                = link_valid[CHAIN_CELLS];
	assign dn_data                 = link_data[CHAIN_CELLS];
	assign link_ready[CHAIN_CELLS] = dn_ready;
endmodule

### sim/tb_uart_line_config_encoder_unit.sv
`timescale 1ns / 100ps

module tb_uart_line_config_encoder_unit;
	import ulce_pkg::*;

	// Handshake pacing modes. Each request word carries the mode that is
	// in force while it is offered. The response side follows the mode of
	// the word at the head of the request queue.
	localparam int PH_FLOW       = 0;
	localparam int PH_SEND_GAPS  = 1;
	localparam int PH_RECV_GAPS  = 2;
	localparam int PH_BOTH_GAPS  = 3;
	localparam int RANDOM_WORDS  = 1800;
	localparam int PHASE_LEN     = 150;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct {
		logic [BAUD_W-1:0] baud;
		logic [FMT_W-1:0]  fmt;
		int                phase;
	} line_request_t;

	typedef struct {
		logic                accepted;
		logic [DIV_W-1:0]    divisor;
		logic [LC_W-1:0]     line_control;
		logic [DIV_BITS-1:0] actual_baud;
	} line_setting_t;

	logic clk;
	logic arst_n;

	ulce_req_if req_ch ();
	ulce_rsp_if rsp_ch ();

	uart_line_config_encoder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Requests not yet taken by the block, and the settings still owed by it.
	line_request_t request_queue[$];
	line_setting_t setting_queue[$];

	logic req_took;
	int   last_phase;
	int   mismatches;
	int   cycle_count;

	// Encodes one request the way the block must: range and code checks
	// first, then the two divisions and the line control packing. Any
	// rejection leaves every field at zero.
	function automatic line_setting_t encode_line_setting(input logic [BAUD_W-1:0] baud,
			input logic [FMT_W-1:0] fmt);
		line_setting_t res;
		logic [2:0]    word;
		logic [2:0]    par;
		logic [1:0]    stop;
		logic          ok;
		int unsigned   div;
		res = '{default: '0};
		word = fmt[2:0];
		par = fmt[5:3];
		stop = fmt[7:6];
		ok = (baud >= BAUD_MIN) && (baud <= BAUD_MAX) && (word <= WORD_5) &&
			(par <= PAR_EVEN) && (stop <= STOP_2) && ((stop != STOP_1P5) || (word == WORD_5));
		if (ok) begin
			div = int'(CLOCK_RATE) / int'(baud);
			res.accepted = 1'b1;
			res.divisor = div[DIV_W-1:0];
			// The length code runs backwards from the word code: 8 bits gives 3.
			res.line_control[1:0] = 2'd3 - word[1:0];
			res.line_control[2] = (stop != STOP_1);
			// Even parity sets both parity bits, odd only the low one.
			res.line_control[4:3] = (par == PAR_EVEN) ? 2'd3 : par[1:0];
			res.actual_baud = DIV_BITS'(int'(CLOCK_RATE) / div);
		end
		return res;
	endfunction

	task automatic push_request(input logic [BAUD_W-1:0] baud, input logic [FMT_W-1:0] fmt,
			input int phase);
		line_request_t r;
		r.baud = baud;
		r.fmt = fmt;
		r.phase = phase;
		request_queue.push_back(r);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// A legal format: stop code 1.5 is only drawn together with 5-bit words.
	function automatic logic [FMT_W-1:0] legal_format();
		logic [2:0] word;
		logic [2:0] par;
		logic [1:0] stop;
		word = 3'($urandom_range(WORD_8, WORD_5));
		par = 3'($urandom_range(PAR_NONE, PAR_EVEN));
		if (word == WORD_5)
			stop = 2'($urandom_range(STOP_1, STOP_2));
		else
			stop = $urandom_range(0, 1) ? STOP_2 : STOP_1;
		return {stop, par, word};
	endfunction

	// Baud rates spread over the decades of the legal range, so both
	// large and small divisors show up.
	function automatic logic [BAUD_W-1:0] legal_baud();
		case ($urandom_range(0, 3))
			0: return BAUD_W'($urandom_range(23, 300));
			1: return BAUD_W'($urandom_range(300, 20000));
			2: return BAUD_W'($urandom_range(20000, 200000));
			default: return BAUD_W'($urandom_range(200000, 1500000));
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Driver. A new request word is offered at the falling edge once the
	// previous one has been taken; while idle the payload carries noise so
	// that the block cannot lean on stale data. The response ready line is
	// also paced here.
	always @(negedge clk) begin : drive
		int ph;
		int send_pct;
		int recv_pct;
		if (arst_n) begin
			ph = (request_queue.size() != 0) ? request_queue[0].phase : last_phase;
			last_phase = ph;
			send_pct = (ph == PH_SEND_GAPS) ? 80 : (ph == PH_BOTH_GAPS) ? 12 : 0;
			recv_pct = (ph == PH_RECV_GAPS) ? 80 : (ph == PH_BOTH_GAPS) ? 12 : 0;
			if (!req_ch.valid || req_took) begin
				if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
					req_ch.valid <= 1'b1;
					req_ch.baud_rate <= request_queue[0].baud;
					req_ch.line_format <= request_queue[0].fmt;
				end else begin
					req_ch.valid <= 1'b0;
					req_ch.baud_rate <= BAUD_W'($urandom);
					req_ch.line_format <= FMT_W'($urandom);
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_pct);
		end
	end

	// Monitor. At the rising edge a taken request word is turned into its
	// expected setting, and a taken response word is checked against the
	// oldest expected setting, field by field.
	always @(posedge clk) begin : watch
		line_setting_t want;
		if (arst_n) begin
			req_took <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				setting_queue.push_back(encode_line_setting(req_ch.baud_rate,
					req_ch.line_format));
				void'(request_queue.pop_front());
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (setting_queue.size() == 0) begin
					$display("%0t: stray response, expected none, actual accepted %0d divisor %0d",
						$time, rsp_ch.accepted, rsp_ch.divisor);
					mismatches++;
				end else begin
					want = setting_queue.pop_front();
					check_field("accepted", want.accepted, rsp_ch.accepted);
					check_field("divisor", want.divisor, rsp_ch.divisor);
					check_field("line_control", want.line_control, rsp_ch.line_control);
					check_field("actual_baud", want.actual_baud, rsp_ch.actual_baud);
				end
			end
		end
	end

	initial begin
		logic [FMT_W-1:0] fmt_8n1;
		logic [FMT_W-1:0] fmt;
		logic [BAUD_W-1:0] baud;
		int phase;
		arst_n = 1'b0;
		req_took = 1'b0;
		last_phase = PH_FLOW;
		mismatches = 0;
		cycle_count = 0;
		req_ch.valid = 1'b0;
		req_ch.baud_rate = '0;
		req_ch.line_format = '0;
		rsp_ch.ready = 1'b0;

		// Directed words. First the baud range edges with the common 8N1 format.
		fmt_8n1 = {STOP_1, PAR_NONE, WORD_8};
		push_request(24'd0, fmt_8n1, PH_FLOW);
		push_request(24'd22, fmt_8n1, PH_FLOW);
		push_request(BAUD_MIN, fmt_8n1, PH_FLOW);
		push_request(24'd24, fmt_8n1, PH_FLOW);
		push_request(BAUD_MAX, fmt_8n1, PH_FLOW);
		push_request(BAUD_MAX + 24'd1, fmt_8n1, PH_FLOW);
		push_request(24'hFFFFFF, fmt_8n1, PH_FLOW);
		push_request(24'd115200, fmt_8n1, PH_FLOW);
		// Every word length, plus word codes past the legal ones.
		push_request(24'd9600, {STOP_1, PAR_NONE, WORD_7}, PH_FLOW);
		push_request(24'd9600, {STOP_1, PAR_NONE, WORD_6}, PH_FLOW);
		push_request(24'd9600, {STOP_1, PAR_NONE, WORD_5}, PH_FLOW);
		push_request(24'd9600, {STOP_1, PAR_NONE, 3'd4}, PH_FLOW);
		push_request(24'd9600, {STOP_1, PAR_NONE, 3'd7}, PH_FLOW);
		// Parity codes, legal and not.
		push_request(24'd9600, {STOP_1, PAR_ODD, WORD_8}, PH_FLOW);
		push_request(24'd9600, {STOP_1, PAR_EVEN, WORD_8}, PH_FLOW);
		push_request(24'd9600, {STOP_1, 3'd3, WORD_8}, PH_FLOW);
		push_request(24'd9600, {STOP_1, 3'd7, WORD_8}, PH_FLOW);
		// Stop codes, including one and a half stop bits with and without 5-bit words.
		push_request(24'd9600, {STOP_2, PAR_EVEN, WORD_7}, PH_FLOW);
		push_request(24'd9600, {2'd3, PAR_NONE, WORD_8}, PH_FLOW);
		push_request(24'd9600, {STOP_1P5, PAR_ODD, WORD_5}, PH_FLOW);
		push_request(24'd9600, {STOP_1P5, PAR_NONE, WORD_8}, PH_FLOW);
		push_request(24'd9600, {STOP_1P5, PAR_NONE, WORD_6}, PH_FLOW);
		push_request(24'd9600, 8'hFF, PH_FLOW);

		// Random words, mostly legal requests with random content; the rest
		// is noise across the whole field range. The pacing mode changes
		// every 150 words.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			phase = (i / PHASE_LEN) % 4;
			if ($urandom_range(0, 99) < 70) begin
				baud = legal_baud();
				fmt = legal_format();
			end else begin
				case ($urandom_range(0, 2))
					0: baud = BAUD_W'($urandom_range(0, 24'hFFFFFF));
					1: baud = BAUD_W'($urandom_range(0, 30));
					default: baud = legal_baud();
				endcase
				fmt = $urandom_range(0, 1) ? FMT_W'($urandom_range(0, 255)) : legal_format();
			end
			push_request(baud, fmt, phase);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: every request taken, every setting returned, then a margin
		// longer than the pipeline so that a stray extra response is caught.
		while (request_queue.size() != 0)
			@(posedge clk);
		while (setting_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
